>>> rtl/dsum_pkg.sv
// Shared types and constants for the Dedekind sum core.
// No dependencies; every other file in rtl but dsum_checker imports this package.
`default_nettype none

package dsum_pkg;

  // Width of the shared shift-subtract divider datapath.
  localparam int DivW = 64;
  localparam int CntW = 7;

  // Dividend bit counts for each use of the divider.
  localparam logic [CntW-1:0] NBITS_HMOD = 7'd32;
  localparam logic [CntW-1:0] NBITS_EUC  = 7'd31;
  localparam logic [CntW-1:0] NBITS_NUM  = 7'd64;
  localparam logic [CntW-1:0] NBITS_DEN  = 7'd36;

  // One classified input transaction as held in the queue.
  typedef struct packed {
    logic        trivial;
    logic        h_neg;
    logic [31:0] h_mag;
    logic [30:0] k;
  } dsum_item_t;

  // Request from the back end to the divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
    logic [CntW-1:0] nbits;
  } dsum_div_req_t;

  // Answer from the divider; done is a one-cycle pulse.
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] rem;
  } dsum_div_rsp_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_HMOD_GO,
    S_HMOD_WT,
    S_EUC_CHK,
    S_EUC_WT,
    S_EUC_M1,
    S_EUC_M2,
    S_EUC_M3,
    S_FIN_MUL,
    S_FIN_SUM,
    S_GCD,
    S_DIVN_GO,
    S_DIVN_WT,
    S_DIVD_GO,
    S_DIVD_WT,
    S_OUT
  } dsum_state_t;

endpackage

`default_nettype wire

>>> rtl/dedekind_sum_euclid_core.sv
// Dedekind sum s(h,k) as a reduced fraction. Each input transaction (h, k) gives one
// output transaction (numerator, denominator). The front end takes a transaction into
// a two-entry queue whenever it has room, so up to two items wait while one is worked
// on. The back end handles one item at a time; trivial items (k of 2 or less, or h
// zero) go straight to the output. Otherwise an item runs h mod k, the Euclid steps
// (up to about 45 steps), a binary gcd and the two final divisions; all but the gcd
// run on the shared one-bit-per-cycle divider.
// Depends on dsum_pkg, dsum_front, dsum_fifo, dsum_div and dsum_back.
`default_nettype none

module dedekind_sum_euclid_core import dsum_pkg::*; #(
  parameter int K_BITS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] h_value,
  input  wire logic [30:0] k_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [62:0]      numerator,
  output logic [34:0]      denominator
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  dsum_item_t    q_item;
  dsum_item_t    q_head;
  dsum_div_req_t div_req;
  dsum_div_rsp_t div_rsp;

  dsum_front #(.K_BITS(K_BITS)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .h_value  (h_value),
    .k_value  (k_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  dsum_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  dsum_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dsum_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .numerator   (numerator),
    .denominator (denominator)
  );

endmodule

`default_nettype wire

>>> rtl/dsum_front.sv
// Front end: accepts input transactions and classifies them for the back end.
// Depends on dsum_pkg for the queue item type.
`default_nettype none

module dsum_front import dsum_pkg::*; #(
  parameter int K_BITS = 31
) (
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] h_value,
  input  wire logic [30:0] k_value,
  input  wire logic        q_full,
  output logic             q_push,
  output dsum_item_t       q_item
);

  localparam logic [30:0] KMASK = 31'((64'd1 << K_BITS) - 64'd1);

  logic [30:0] k_m;

  // Take a transaction whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Mask k, split h into sign and magnitude, and flag items with a zero result.
  assign k_m              = k_value & KMASK;
  assign q_item.k         = k_m;
  assign q_item.h_neg     = h_value[31];
  assign q_item.h_mag     = h_value[31] ? (32'd0 - h_value) : h_value;
  assign q_item.trivial   = (k_m <= 31'd2) || (h_value == 32'd0);

endmodule

`default_nettype wire

>>> rtl/dsum_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on dsum_pkg for the item type.
`default_nettype none

module dsum_fifo import dsum_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  dsum_item_t      push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output dsum_item_t      head
);

  dsum_item_t  mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsum_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dsum_pkg for the request and response structs.
`default_nettype none

module dsum_div import dsum_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  dsum_div_req_t req,
  output dsum_div_rsp_t rsp
);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DivW-1:0] dvd;
  logic [DivW-1:0] dvs;
  logic [DivW-1:0] quo;
  logic [DivW:0]   rem;
  logic            done;
  logic [5:0]      idx;
  logic [DivW:0]   rem_sh;
  logic            fits;

  // Bring down the next dividend bit and try a subtract.
  assign idx    = 6'(cnt - 7'd1);
  assign rem_sh = {rem[DivW-1:0], dvd[idx]};
  assign fits   = rem_sh >= {1'b0, dvs};

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[DivW-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo[idx] <= fits;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsum_back.sv
// Back end: runs h mod k, the Euclidean recurrence, the final fraction and its reduction.
// Depends on dsum_pkg and drives the shared dsum_div divider.
`default_nettype none

module dsum_back import dsum_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  dsum_item_t       q_head,
  output logic             q_pop,
  output dsum_div_req_t    div_req,
  input  dsum_div_rsp_t    div_rsp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [62:0]      numerator,
  output logic [34:0]      denominator
);

  dsum_state_t st;
  dsum_state_t st_next;

  logic               h_neg;
  logic [31:0]        h_mag;
  logic [30:0]        k;
  logic [30:0]        a;
  logic [30:0]        b;
  logic [30:0]        q;
  logic [30:0]        r;
  logic [31:0]        m11;
  logic [31:0]        m12;
  logic [31:0]        m21;
  logic [31:0]        m22;
  logic signed [32:0] t;
  logic               odd;
  logic [63:0]        prod;
  logic [63:0]        mag;
  logic [63:0]        den;
  logic               nneg;
  logic [63:0]        u;
  logic [63:0]        v;
  logic [5:0]         s;
  logic [63:0]        g;
  logic [62:0]        num_out;
  logic [34:0]        den_out;

  logic [30:0]        r0;
  logic signed [32:0] t_adj;
  logic signed [65:0] sprod;
  logic [63:0]        nsum;

  assign out_valid   = (st == S_OUT);
  assign numerator   = num_out;
  assign denominator = den_out;
  assign q_pop       = (st == S_IDLE) && q_valid;

  // Final product and sum for the unreduced numerator.
  assign r0    = div_rsp.rem[30:0];
  assign t_adj = odd ? (t - 33'sd3) : t;
  assign sprod = t_adj * $signed({1'b0, m11});
  assign nsum  = odd ? (prod + 64'({m21} + {m12}))
                     : (prod + 64'($signed({1'b0, m21}) - $signed({1'b0, m12})));

  // Divider requests per state.
  always_comb begin
    div_req = '0;
    unique case (st)
      S_HMOD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(h_mag);
        div_req.divisor  = 64'(k);
        div_req.nbits    = NBITS_HMOD;
      end
      S_EUC_CHK: begin
        div_req.start    = (b != 31'd0);
        div_req.dividend = 64'(a);
        div_req.divisor  = 64'(b);
        div_req.nbits    = NBITS_EUC;
      end
      S_DIVN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag;
        div_req.divisor  = g;
        div_req.nbits    = NBITS_NUM;
      end
      S_DIVD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = den;
        div_req.divisor  = g;
        div_req.nbits    = NBITS_DEN;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:    if (q_valid) st_next = q_head.trivial ? S_OUT : S_HMOD_GO;
      S_HMOD_GO: st_next = S_HMOD_WT;
      S_HMOD_WT: if (div_rsp.done) st_next = S_EUC_CHK;
      S_EUC_CHK: st_next = (b != 31'd0) ? S_EUC_WT : S_FIN_MUL;
      S_EUC_WT:  if (div_rsp.done) st_next = S_EUC_M1;
      S_EUC_M1:  st_next = S_EUC_M2;
      S_EUC_M2:  st_next = S_EUC_M3;
      S_EUC_M3:  st_next = S_EUC_CHK;
      S_FIN_MUL: st_next = S_FIN_SUM;
      S_FIN_SUM: st_next = S_GCD;
      S_GCD:     if (u == 64'd0) st_next = S_DIVN_GO;
      S_DIVN_GO: st_next = S_DIVN_WT;
      S_DIVN_WT: if (div_rsp.done) st_next = S_DIVD_GO;
      S_DIVD_GO: st_next = S_DIVD_WT;
      S_DIVD_WT: if (div_rsp.done) st_next = S_OUT;
      S_OUT:     if (out_ready) st_next = S_IDLE;
      default:   st_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath registers, updated by the states that own them.
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        h_neg   <= q_head.h_neg;
        h_mag   <= q_head.h_mag;
        k       <= q_head.k;
        num_out <= '0;
        den_out <= 35'd1;
      end
      S_HMOD_WT: begin
        // Floor remainder: a negative h with a nonzero remainder wraps up by k.
        a   <= k;
        b   <= (h_neg && (r0 != 31'd0)) ? (k - r0) : r0;
        m11 <= 32'd1;
        m12 <= 32'd0;
        m21 <= 32'd0;
        m22 <= 32'd1;
        t   <= '0;
        odd <= 1'b0;
      end
      S_EUC_WT: begin
        q <= div_rsp.quo[30:0];
        r <= r0;
      end
      S_EUC_M1: begin
        prod <= {32'd0, 1'b0, q} * {32'd0, m11};
      end
      S_EUC_M2: begin
        m11  <= m12 + prod[31:0];
        m12  <= m11;
        prod <= {32'd0, 1'b0, q} * {32'd0, m21};
      end
      S_EUC_M3: begin
        m21 <= m22 + prod[31:0];
        m22 <= m21;
        a   <= b;
        b   <= r;
        t   <= odd ? (t - $signed({2'b0, q})) : (t + $signed({2'b0, q}));
        odd <= ~odd;
      end
      S_FIN_MUL: begin
        prod <= sprod[63:0];
      end
      S_FIN_SUM: begin
        nneg <= nsum[63];
        mag  <= nsum[63] ? (64'd0 - nsum) : nsum;
        u    <= nsum[63] ? (64'd0 - nsum) : nsum;
        den  <= 64'({m11, 3'b000}) + 64'({m11, 2'b00});
        v    <= 64'({m11, 3'b000}) + 64'({m11, 2'b00});
        s    <= '0;
      end
      S_GCD: begin
        // Binary gcd, one shift or subtract-and-shift per cycle.
        if (u == 64'd0) begin
          g <= v << s;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          s <= s + 6'd1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= (u - v) >> 1;
        end else begin
          v <= (v - u) >> 1;
        end
      end
      S_DIVN_WT: begin
        if (div_rsp.done) begin
          num_out <= nneg ? (63'd0 - div_rsp.quo[62:0]) : div_rsp.quo[62:0];
        end
      end
      S_DIVD_WT: begin
        if (div_rsp.done) begin
          den_out <= div_rsp.quo[34:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dsum_checker.sv
// Port-level checks for dedekind_sum_euclid_core, attached by a bind statement.
// Depends only on the top level's ports.
`default_nettype none

module dsum_sva (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [62:0] numerator,
  input wire logic [34:0] denominator
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(numerator) && $stable(denominator))
    else $error("stalled result changed");

  // The denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> denominator != 35'd0)
    else $error("zero denominator");

  // A zero sum is reported as 0/1.
  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && numerator == 63'd0 |-> denominator == 35'd1)
    else $error("zero numerator not over one");

  // A reduced fraction never has both parts even.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (numerator[0] || denominator[0]))
    else $error("fraction not reduced");

endmodule

bind dedekind_sum_euclid_core dsum_sva u_dsum_sva (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .numerator   (numerator),
  .denominator (denominator)
);

`default_nettype wire
